@@ sv/b58pe_pkg.sv @@
// Shared package for the prefixed base58 encoder.
// Holds fixed widths, prefix byte codes, the digit alphabet and shared types.
// No dependencies.
package b58pe_pkg;

    localparam int VALUE_W = 64;   // width of the input value field
    localparam int BYTE_W  = 8;    // width of one output text byte
    localparam int DIGIT_W = 6;    // one base58 digit, 0..57
    localparam int CHUNK_W = 8;    // dividend bits retired per divider cycle
    localparam int RADIX   = 58;

    localparam logic [BYTE_W-1:0] PREFIX_UTF8_HI = 8'hC6;
    localparam logic [BYTE_W-1:0] PREFIX_UTF8_LO = 8'h92;
    localparam logic [BYTE_W-1:0] PREFIX_ASCII   = 8'h66;   // 'f'

    typedef logic [BYTE_W-1:0] t_byte;

    // Queue status seen by both sides of the decoupling queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_sts;

    // Upper bound on the digit count of a bits-wide value: ceil(bits / log2(58)),
    // rounded up generously so it never falls short.
    function automatic int max_digits(input int bits);
        int n;
        n = (bits * 1000 + 5856) / 5857;
        return n;
    endfunction

    // Map one digit to its alphabet character.
    function automatic t_byte b58_char(input logic [DIGIT_W-1:0] d);
        t_byte c;
        if (d < 6'd9) begin
            c = 8'h31 + BYTE_W'(d);                 // '1'..'9'
        end else if (d < 6'd17) begin
            c = 8'h41 + BYTE_W'(d - 6'd9);          // 'A'..'H'
        end else if (d < 6'd22) begin
            c = 8'h4A + BYTE_W'(d - 6'd17);         // 'J'..'N'
        end else if (d < 6'd33) begin
            c = 8'h50 + BYTE_W'(d - 6'd22);         // 'P'..'Z'
        end else if (d < 6'd44) begin
            c = 8'h61 + BYTE_W'(d - 6'd33);         // 'a'..'k'
        end else begin
            c = 8'h6D + BYTE_W'(d - 6'd44);         // 'm'..'z'
        end
        return c;
    endfunction

endpackage

@@ sv/b58pe_if.sv @@
// Channel interfaces of the prefixed base58 encoder: input value and output byte.
// Depends on b58pe_pkg.
interface b58pe_in_if;
    import b58pe_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b58pe_out_if;
    import b58pe_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ sv/b58pe_front.sv @@
// Front end: accepts a value and splits it into base58 digits with a
// radix-58 restoring divider. Depends on b58pe_pkg and b58pe_in_if.
module b58pe_front #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIG    = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    b58pe_in_if.sink              i_in,
    input  b58pe_pkg::t_fifo_sts  i_sts,
    output logic                  o_push,
    output logic [$clog2(MAX_DIG)+MAX_DIG*b58pe_pkg::DIGIT_W-1:0] o_job
);
    import b58pe_pkg::*;

    localparam int PadW   = ((VALUE_BITS + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
    localparam int NChunk = PadW / CHUNK_W;
    localparam int ChW    = $clog2(NChunk + 1);
    localparam int IdxW   = $clog2(MAX_DIG);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                           r_state, n_state;
    logic [PadW-1:0]                   r_work;
    logic [DIGIT_W-1:0]                r_rem;
    logic [ChW-1:0]                    r_chunk;
    logic [IdxW-1:0]                   r_ndig;
    logic [IdxW-1:0]                   r_last;
    logic [MAX_DIG-1:0][DIGIT_W-1:0]   r_dig;

    logic [DIGIT_W:0]                  step;
    logic [DIGIT_W-1:0]                rem;
    logic [CHUNK_W-1:0]                qbits;
    logic [PadW-1:0]                   n_work;
    logic                              last_chunk;
    logic                              done;

    // Eight restoring steps over the top chunk of the working dividend.
    always_comb begin
        rem   = r_rem;
        step  = '0;
        qbits = '0;
        for (int k = 0; k < CHUNK_W; k++) begin
            step = {rem, r_work[PadW-1-k]};
            if (step >= (DIGIT_W+1)'(RADIX)) begin
                qbits[CHUNK_W-1-k] = 1'b1;
                rem = DIGIT_W'(step - (DIGIT_W+1)'(RADIX));
            end else begin
                rem = step[DIGIT_W-1:0];
            end
        end
        n_work     = (r_work << CHUNK_W) | PadW'(qbits);
        last_chunk = (r_chunk == ChW'(NChunk - 1));
        done       = (n_work == '0) || (r_ndig == IdxW'(MAX_DIG - 1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_in.valid) n_state = F_DIV;
            end
            F_DIV: begin
                if (last_chunk && done) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_sts.full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in.valid) begin
            r_work  <= PadW'(i_in.value[VALUE_BITS-1:0]);
            r_rem   <= '0;
            r_chunk <= '0;
            r_ndig  <= '0;
        end else if (r_state == F_DIV) begin
            r_work <= n_work;
            if (last_chunk) begin
                r_dig[r_ndig] <= rem;
                r_rem   <= '0;
                r_chunk <= '0;
                r_last  <= r_ndig;
                if (!done) r_ndig <= r_ndig + IdxW'(1);
            end else begin
                r_rem   <= rem;
                r_chunk <= r_chunk + ChW'(1);
            end
        end
    end

    assign i_in.ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_sts.full;
    assign o_job      = {r_last, r_dig};

endmodule

@@ sv/b58pe_fifo.sv @@
// Two-entry queue between the digit front end and the byte back end.
// Depends on b58pe_pkg.
module b58pe_fifo #(
    parameter int W = 70
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [W-1:0]         i_din,
    input  logic                 i_pop,
    output logic [W-1:0]         o_dout,
    output b58pe_pkg::t_fifo_sts o_sts
);
    import b58pe_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_din;
    end

    assign o_dout      = r_mem[r_rp];
    assign o_sts.full  = (r_cnt == 2'd2);
    assign o_sts.empty = (r_cnt == 2'd0);

endmodule

@@ sv/b58pe_back.sv @@
// Back end: emits prefix bytes and the digits of the queue head, most
// significant first, through a registered output. Depends on b58pe_pkg, b58pe_out_if.
module b58pe_back #(
    parameter int MAX_DIG = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ascii,
    input  logic [$clog2(MAX_DIG)+MAX_DIG*b58pe_pkg::DIGIT_W-1:0] i_job,
    input  b58pe_pkg::t_fifo_sts i_sts,
    output logic                 o_pop,
    b58pe_out_if.source          o_out
);
    import b58pe_pkg::*;

    localparam int IdxW = $clog2(MAX_DIG);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_PRE1 = 3'b010,
        B_DIG  = 3'b100
    } t_bstate;

    t_bstate                          r_state, n_state;
    logic [IdxW-1:0]                  r_idx;
    logic                             r_ovalid;
    t_byte                            r_obyte;
    logic                             r_olast;

    logic [IdxW-1:0]                  h_last;
    logic [MAX_DIG-1:0][DIGIT_W-1:0]  h_dig;
    logic                             slot_free;
    logic                             emit;
    t_byte                            e_byte;
    logic                             e_last;

    assign {h_last, h_dig} = i_job;
    assign slot_free       = !r_ovalid || o_out.ready;

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        e_byte  = PREFIX_ASCII;
        e_last  = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_sts.empty && slot_free) begin
                    emit    = 1'b1;
                    e_byte  = i_ascii ? PREFIX_ASCII : PREFIX_UTF8_HI;
                    n_state = i_ascii ? B_DIG : B_PRE1;
                end
            end
            B_PRE1: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = PREFIX_UTF8_LO;
                    n_state = B_DIG;
                end
            end
            B_DIG: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_byte = b58_char(h_dig[r_idx]);
                    e_last = (r_idx == '0);
                    if (r_idx == '0) begin
                        o_pop   = 1'b1;
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (slot_free) r_ovalid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= e_byte;
            r_olast <= e_last;
        end
        if (r_state == B_IDLE) begin
            r_idx <= h_last;
        end else if (r_state == B_DIG && slot_free && r_idx != '0) begin
            r_idx <= r_idx - IdxW'(1);
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;

endmodule

@@ sv/base58_prefixed_encoder.sv @@
// Top level of the prefixed base58 encoder: config register, front end,
// queue and back end. Depends on b58pe_pkg, b58pe_if, b58pe_front, b58pe_fifo and b58pe_back.

// Each transaction on i_in carries one value; its low VALUE_BITS bits are
// turned into text sent on o_out one byte per transaction: first the prefix
// (0xC6 0x92 when the ascii_prefix register is 0, the single byte 'f' when it
// is 1), then the base58 digits, most significant first, with last set on the
// final byte. Zero encodes as the digit '1'. Digits come from a radix-58
// restoring divider that retires 8 dividend bits per cycle; the front end
// takes no new value until the digits of the last one are pushed, and that
// divider sets the sustained rate. The back end sends the prefix and then
// one byte per digit, at one per cycle unless o_out stalls, while the
// front end already works on the next value; a two-entry queue sits between
// them. Write ascii_prefix through i_cfg_we/i_cfg_wdata only while the block
// is idle.
module base58_prefixed_encoder #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b58pe_in_if.sink    i_in,
    b58pe_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);
    import b58pe_pkg::*;

    localparam int MaxDig = max_digits(VALUE_BITS);
    localparam int JobW   = $clog2(MaxDig) + MaxDig * DIGIT_W;

    logic            r_ascii;
    logic            push;
    logic            pop;
    logic [JobW-1:0] job_in;
    logic [JobW-1:0] job_out;
    t_fifo_sts       sts;

    // Prefix select register; reset picks the UTF-8 prefix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii <= 1'b0;
        end else if (i_cfg_we) begin
            r_ascii <= i_cfg_wdata;
        end
    end

    // Split the value into digits, least significant first.
    b58pe_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIG    (MaxDig)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_sts   (sts),
        .o_push  (push),
        .o_job   (job_in)
    );

    // Hold finished digit sets until the back end is free.
    b58pe_fifo #(
        .W (JobW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (job_in),
        .i_pop   (pop),
        .o_dout  (job_out),
        .o_sts   (sts)
    );

    // Emit prefix and digits, most significant first.
    b58pe_back #(
        .MAX_DIG (MaxDig)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ascii (r_ascii),
        .i_job   (job_out),
        .i_sts   (sts),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ sv/b58pe_checker.sv @@
// Port-level checks for the prefixed base58 encoder, bound to the top level.
// Depends on b58pe_pkg and base58_prefixed_encoder.
module b58pe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    import b58pe_pkg::*;

    // A stalled output byte holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output byte changed while stalled");

    // The first UTF-8 prefix byte is always followed at once by the second.
    a_utf8_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_byte == PREFIX_UTF8_HI |=>
            i_out_valid && i_out_byte == PREFIX_UTF8_LO)
        else $error("UTF-8 prefix not followed by its second byte");

    // Prefix-only bytes never end a text.
    a_prefix_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_byte == PREFIX_UTF8_HI || i_out_byte == PREFIX_UTF8_LO)
            |-> !i_out_last)
        else $error("prefix byte marked last");

    // A byte following the last one starts a new text with a prefix byte.
    a_new_text_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last ##1 i_out_valid |->
            i_out_byte == PREFIX_UTF8_HI || i_out_byte == PREFIX_ASCII)
        else $error("text does not open with a prefix byte");

endmodule

bind base58_prefixed_encoder b58pe_checker u_b58pe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
